### rtl/itp_pkg.sv
package itp_pkg;

  // Default operator stack depth
  localparam int STACK_DEPTH_DEFAULT = 16;

  // Command queue between front and back; depth must be a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // ASCII characters of interest
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_NONE   = 8'h00;

  // Operator codes held on the stack
  localparam logic [2:0] OP_OPEN   = 3'd0;
  localparam logic [2:0] OP_PLUS   = 3'd1;
  localparam logic [2:0] OP_MINUS  = 3'd2;
  localparam logic [2:0] OP_TIMES  = 3'd3;
  localparam logic [2:0] OP_DIVIDE = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_BAD   = 3'd1;
  localparam logic [2:0] ST_CLOSE = 3'd2;
  localparam logic [2:0] ST_OPEN  = 3'd3;
  localparam logic [2:0] ST_OVER  = 3'd4;

  // Command kinds sent from front to back
  localparam logic [2:0] K_NUM   = 3'd0;
  localparam logic [2:0] K_SPACE = 3'd1;
  localparam logic [2:0] K_BAD   = 3'd2;
  localparam logic [2:0] K_OPEN  = 3'd3;
  localparam logic [2:0] K_CLOSE = 3'd4;
  localparam logic [2:0] K_OP    = 3'd5;
  localparam logic [2:0] K_END   = 3'd6;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_expr;
  } in_item_t;

  typedef struct packed {
    logic       has_char;
    logic [7:0] out_char;
    logic       last;
    logic [2:0] status;
  } out_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic [2:0] code;
    logic       close_num;
  } cmd_t;

  function automatic logic [7:0] op_char(input logic [2:0] code);
    logic [7:0] c;
    case (code)
      OP_PLUS:   c = CH_PLUS;
      OP_MINUS:  c = CH_MINUS;
      OP_TIMES:  c = CH_STAR;
      OP_DIVIDE: c = CH_SLASH;
      default:   c = CH_LPAREN;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] op_rank(input logic [2:0] code);
    logic [1:0] r;
    case (code)
      OP_PLUS, OP_MINUS:  r = 2'd1;
      OP_TIMES, OP_DIVIDE: r = 2'd2;
      default:            r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/itp_front.sv
module itp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  itp_pkg::in_item_t item,
  output logic             cmd_valid,
  input  logic             cmd_stall,
  output itp_pkg::cmd_t    cmd
);
  import itp_pkg::*;

  logic in_number;
  logic is_num;

  assign cmd_valid  = item_valid;
  assign item_stall = cmd_stall;

  assign is_num = (item.in_char >= CH_ZERO && item.in_char <= CH_NINE) ||
                  item.in_char == CH_DOT;

  always_comb begin
    cmd.ch        = item.in_char;
    cmd.code      = OP_OPEN;
    cmd.close_num = in_number && !(is_num && !item.end_of_expr);
    if (item.end_of_expr) begin
      cmd.kind = K_END;
    end else if (is_num) begin
      cmd.kind = K_NUM;
    end else begin
      case (item.in_char)
        CH_SPACE:  cmd.kind = K_SPACE;
        CH_LPAREN: cmd.kind = K_OPEN;
        CH_RPAREN: cmd.kind = K_CLOSE;
        CH_PLUS: begin
          cmd.kind = K_OP;
          cmd.code = OP_PLUS;
        end
        CH_MINUS: begin
          cmd.kind = K_OP;
          cmd.code = OP_MINUS;
        end
        CH_STAR: begin
          cmd.kind = K_OP;
          cmd.code = OP_TIMES;
        end
        CH_SLASH: begin
          cmd.kind = K_OP;
          cmd.code = OP_DIVIDE;
        end
        default:   cmd.kind = K_BAD;
      endcase
    end
  end

  // Track an open number across transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_number <= 1'b0;
    end else if (item_valid && !item_stall) begin
      in_number <= is_num && !item.end_of_expr;
    end
  end

endmodule

### rtl/itp_queue.sv
module itp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_stall,
  input  itp_pkg::cmd_t wr_data,
  output logic          rd_valid,
  input  logic          rd_stall,
  output itp_pkg::cmd_t rd_data
);
  import itp_pkg::*;

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;
  logic                wr_go;
  logic                rd_go;

  assign wr_stall = fill == (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign rd_valid = fill != '0;
  assign rd_data  = entries[rd_ptr];
  assign wr_go    = wr_valid && !wr_stall;
  assign rd_go    = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_go) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_go) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_go && !rd_go) begin
        fill <= fill + 1'b1;
      end else if (rd_go && !wr_go) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_go) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

### rtl/itp_back.sv
module itp_back #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  itp_pkg::cmd_t     cmd,
  output logic              result_valid,
  input  logic              result_stall,
  output itp_pkg::out_item_t result
);
  import itp_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);

  logic [2:0]       stack_mem [STACK_DEPTH];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] top_pos;
  logic [2:0]       top;
  logic             sp_done;
  logic             pend_valid;
  logic [7:0]       pend_char;
  logic             open_seen;

  logic       out_free;
  logic       need_sp;
  logic       stk_full;
  logic       stk_empty;
  logic       top_open;
  logic       go;
  logic       fin;
  logic       fin_generic;
  logic       fin_end;
  logic [2:0] fin_status;
  logic       push;
  logic       pop;
  logic [2:0] push_code;
  logic       prod;
  logic [7:0] prod_char;
  logic       open_hit;
  logic       send;
  out_item_t  send_item;

  assign out_free  = !result_valid || !result_stall;
  assign need_sp   = cmd.close_num && !sp_done;
  assign stk_full  = count == CNT_W'(STACK_DEPTH);
  assign stk_empty = count == '0;
  assign top_open  = top == OP_OPEN;

  always_comb begin
    fin         = 1'b0;
    fin_generic = 1'b0;
    fin_end     = 1'b0;
    fin_status  = ST_OK;
    push        = 1'b0;
    pop         = 1'b0;
    push_code   = cmd.code;
    prod        = 1'b0;
    prod_char   = CH_SPACE;
    open_hit    = 1'b0;
    send        = 1'b0;
    send_item   = '{1'b0, CH_NONE, 1'b1, ST_OK};

    case (cmd.kind)
      K_NUM: begin
        send      = 1'b1;
        send_item = '{1'b1, cmd.ch, 1'b1, ST_OK};
        fin       = 1'b1;
      end
      K_SPACE: begin
        send      = cmd.close_num;
        send_item = '{1'b1, CH_SPACE, 1'b1, ST_OK};
        fin       = 1'b1;
      end
      K_BAD: begin
        send      = 1'b1;
        send_item = '{cmd.close_num, cmd.close_num ? CH_SPACE : CH_NONE, 1'b1, ST_BAD};
        fin       = 1'b1;
      end
      K_OPEN: begin
        push      = !stk_full;
        push_code = OP_OPEN;
        send      = cmd.close_num || stk_full;
        send_item = '{cmd.close_num, cmd.close_num ? CH_SPACE : CH_NONE, 1'b1,
                      stk_full ? ST_OVER : ST_OK};
        fin       = 1'b1;
      end
      K_OP: begin
        if (need_sp) begin
          prod = 1'b1;
        end else if (!stk_empty && !top_open && op_rank(top) >= op_rank(cmd.code)) begin
          prod      = 1'b1;
          prod_char = op_char(top);
          pop       = 1'b1;
        end else begin
          push        = !stk_full;
          fin_generic = 1'b1;
          fin_status  = stk_full ? ST_OVER : ST_OK;
        end
      end
      K_CLOSE: begin
        if (need_sp) begin
          prod = 1'b1;
        end else if (!stk_empty && !top_open) begin
          prod      = 1'b1;
          prod_char = op_char(top);
          pop       = 1'b1;
        end else begin
          // Discard the matching open, or flag a close with none
          pop         = !stk_empty;
          fin_generic = 1'b1;
          fin_status  = stk_empty ? ST_CLOSE : ST_OK;
        end
      end
      K_END: begin
        if (need_sp) begin
          prod = 1'b1;
        end else if (!stk_empty) begin
          pop       = 1'b1;
          open_hit  = top_open;
          prod      = !top_open;
          prod_char = op_char(top);
        end else begin
          fin_generic = 1'b1;
          fin_end     = 1'b1;
          fin_status  = open_seen ? ST_OPEN : ST_OK;
        end
      end
      default: begin
        fin = 1'b1;
      end
    endcase

    // Hand the held character on once the next one is known
    if (prod && pend_valid) begin
      send      = 1'b1;
      send_item = '{1'b1, pend_char, 1'b0, ST_OK};
    end

    if (fin_generic) begin
      fin = 1'b1;
      if (pend_valid) begin
        send      = 1'b1;
        send_item = '{1'b1, pend_char, 1'b1, fin_status};
      end else if (fin_status != ST_OK || fin_end) begin
        send      = 1'b1;
        send_item = '{1'b0, CH_NONE, 1'b1, fin_status};
      end
    end

    go         = cmd_valid && (!send || out_free);
    cmd_stall  = !(go && fin);
    count_next = count;
    if (go && push) begin
      count_next = count + 1'b1;
    end else if (go && pop) begin
      count_next = count - 1'b1;
    end
    top_pos = count_next - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      sp_done      <= 1'b0;
      pend_valid   <= 1'b0;
      open_seen    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (go) begin
        count <= count_next;
        if (fin) begin
          sp_done    <= 1'b0;
          pend_valid <= 1'b0;
          open_seen  <= 1'b0;
        end else begin
          sp_done    <= 1'b1;
          pend_valid <= pend_valid || prod;
          open_seen  <= open_seen || open_hit;
        end
      end
      if (go && send) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Stack storage; top holds the entry just below count
  always_ff @(posedge clk) begin
    if (go && push) begin
      stack_mem[count[IDX_W-1:0]] <= push_code;
      top                         <= push_code;
    end else begin
      top <= stack_mem[top_pos[IDX_W-1:0]];
    end
    if (go && prod) begin
      pend_char <= prod_char;
    end
    if (go && send) begin
      result <= send_item;
    end
  end

endmodule

### rtl/infix_to_postfix_converter_unit.sv
// Infix to postfix converter: operator stack behind a two-entry command queue.
// A digit, '.', space, '(' or bad character is handled directly; an operator or ')'
// first emits the closing space of an open number, then pops stacked operators in
// turn; the end marker emits the space and then empties the stack entry by entry.
// Reset: synchronous; clears the stack count, number flag, queue and output.
module infix_to_postfix_converter_unit #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  itp_pkg::in_item_t item,
  output logic              result_valid,
  input  logic              result_stall,
  output itp_pkg::out_item_t result
);
  import itp_pkg::*;

  logic front_valid;
  logic front_stall;
  cmd_t front_cmd;
  logic back_valid;
  logic back_stall;
  cmd_t back_cmd;

  itp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cmd_valid  (front_valid),
    .cmd_stall  (front_stall),
    .cmd        (front_cmd)
  );

  itp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_stall (front_stall),
    .wr_data  (front_cmd),
    .rd_valid (back_valid),
    .rd_stall (back_stall),
    .rd_data  (back_cmd)
  );

  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (back_valid),
    .cmd_stall    (back_stall),
    .cmd          (back_cmd),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

### bench/infix_to_postfix_converter_unit_tb.sv
`timescale 1ns / 1ps

module infix_to_postfix_converter_unit_tb;
  import itp_pkg::*;

  localparam int STK_MAX    = STACK_DEPTH_DEFAULT;
  localparam int QUIET_MAX  = 3000;
  localparam int HOLD_LEN   = 300;
  localparam int TAIL_LEN   = 40;

  typedef struct {
    in_item_t  it;
    int        reps;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  in_item_t   item = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  out_item_t  result;

  // predictor state
  logic [2:0]  op_stk [STK_MAX];
  int          stk_used = 0;
  bit          num_open = 1'b0;
  out_item_t   postfix_q [$];

  stim_row_t   stim_rows [$];
  stim_row_t   typed_q [$];
  int          items_sent = 0;
  int          bad_results = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;

  infix_to_postfix_converter_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [7:0] stacked_char(input logic [2:0] code);
    case (code)
      OP_PLUS:   return CH_PLUS;
      OP_MINUS:  return CH_MINUS;
      OP_TIMES:  return CH_STAR;
      default:   return CH_SLASH;
    endcase
  endfunction

  function automatic int prec(input logic [2:0] code);
    if (code == OP_TIMES || code == OP_DIVIDE) return 2;
    if (code == OP_OPEN) return 0;
    return 1;
  endfunction

  function automatic void emit(input logic [7:0] ch);
    out_item_t r;
    r.has_char = 1'b1;
    r.out_char = ch;
    r.last     = 1'b0;
    r.status   = ST_OK;
    postfix_q.push_back(r);
  endfunction

  // Shunting-yard step: append the characters one input causes to postfix_q
  function automatic void shunt_char(input in_item_t it);
    int         base;
    logic [2:0] st;
    logic [2:0] top;
    logic [2:0] code;
    bit         found;
    bit         is_num;
    out_item_t  r;
    base   = postfix_q.size();
    st     = ST_OK;
    found  = 1'b0;
    is_num = (it.in_char >= CH_ZERO && it.in_char <= CH_NINE) || it.in_char == CH_DOT;
    if (!it.end_of_expr && is_num) begin
      emit(it.in_char);
      num_open = 1'b1;
    end else begin
      if (num_open) begin
        emit(CH_SPACE);
        num_open = 1'b0;
      end
      if (it.end_of_expr) begin
        while (stk_used > 0) begin
          top = op_stk[stk_used-1];
          stk_used--;
          if (top == OP_OPEN) st = ST_OPEN;
          else emit(stacked_char(top));
        end
      end else if (it.in_char == CH_SPACE) begin
      end else if (it.in_char == CH_LPAREN) begin
        if (stk_used >= STK_MAX) st = ST_OVER;
        else begin
          op_stk[stk_used] = OP_OPEN;
          stk_used++;
        end
      end else if (it.in_char == CH_RPAREN) begin
        while (stk_used > 0 && !found) begin
          top = op_stk[stk_used-1];
          stk_used--;
          if (top == OP_OPEN) found = 1'b1;
          else emit(stacked_char(top));
        end
        if (!found) st = ST_CLOSE;
      end else if (it.in_char == CH_PLUS || it.in_char == CH_MINUS ||
                   it.in_char == CH_STAR || it.in_char == CH_SLASH) begin
        case (it.in_char)
          CH_PLUS:  code = OP_PLUS;
          CH_MINUS: code = OP_MINUS;
          CH_STAR:  code = OP_TIMES;
          default:  code = OP_DIVIDE;
        endcase
        // pop while the top ranks at least as high; '(' is a floor
        while (stk_used > 0 && op_stk[stk_used-1] != OP_OPEN &&
               prec(op_stk[stk_used-1]) >= prec(code)) begin
          emit(stacked_char(op_stk[stk_used-1]));
          stk_used--;
        end
        if (stk_used >= STK_MAX) st = ST_OVER;
        else begin
          op_stk[stk_used] = code;
          stk_used++;
        end
      end else begin
        st = ST_BAD;
      end
    end
    if (postfix_q.size() == base && (st != ST_OK || it.end_of_expr)) begin
      r.has_char = 1'b0;
      r.out_char = CH_NONE;
      r.last     = 1'b0;
      r.status   = ST_OK;
      postfix_q.push_back(r);
    end
    if (postfix_q.size() > base) begin
      postfix_q[postfix_q.size()-1].last   = 1'b1;
      postfix_q[postfix_q.size()-1].status = st;
    end
    if (it.end_of_expr) begin
      stk_used = 0;
      num_open = 1'b0;
    end
  endfunction

  function automatic void check_result(input out_item_t got);
    out_item_t want;
    if (postfix_q.size() == 0) begin
      bad_results++;
      if (bad_results <= 10)
        $display("unexpected result: has=%0d char=%h last=%0d st=%0d",
                 got.has_char, got.out_char, got.last, got.status);
      return;
    end
    want = postfix_q.pop_front();
    if (got.has_char !== want.has_char || got.out_char !== want.out_char ||
        got.last !== want.last || got.status !== want.status) begin
      bad_results++;
      if (bad_results <= 10)
        $display({"mismatch: exp has=%0d char=%h last=%0d st=%0d, ",
                  "got has=%0d char=%h last=%0d st=%0d"},
                 want.has_char, want.out_char, want.last, want.status,
                 got.has_char, got.out_char, got.last, got.status);
    end
  endfunction

  // Predict on each input transfer, check each result transfer, watch for hangs
  always @(posedge clk) begin : port_watch
    int        base;
    stim_row_t row_now;
    if (!rst) begin
      quiet_cycles = quiet_cycles + 1;
      if (item_valid && !item_stall) begin
        base = postfix_q.size();
        shunt_char(item);
        if (typed_q.size() > 0) begin
          row_now = typed_q.pop_front();
          if (row_now.typed) begin
            while (postfix_q.size() > base) postfix_q.delete(postfix_q.size()-1);
            postfix_q.push_back(row_now.want);
          end
        end
        quiet_cycles = 0;
      end
      if (result_valid && !result_stall) begin
        check_result(result);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= QUIET_MAX) begin
        $display("infix_to_postfix_converter_unit_tb: FAIL");
        $finish;
      end
    end
  end

  // Receiver: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    stim_row_t r;
    r.it    = it;
    r.reps  = 1;
    r.typed = typed;
    r.want  = want;
    typed_q.push_back(r);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  task automatic send_char(input logic [7:0] ch, input bit eoe);
    in_item_t it;
    it.in_char     = ch;
    it.end_of_expr = eoe;
    send_item(it, 1'b0, '0);
  endtask

  task automatic send_num();
    int len;
    len = $urandom_range(1, 4);
    repeat (len) begin
      if ($urandom_range(7) == 0) send_char(CH_DOT, 1'b0);
      else send_char(8'(CH_ZERO + $urandom_range(9)), 1'b0);
    end
  endtask

  function automatic logic [7:0] pick_op();
    case ($urandom_range(3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  // One expression: mostly well formed, some deep nesting, noise and broken ones
  task automatic gen_expr();
    int kind;
    int terms;
    int opens;
    int k;
    int j;
    kind = $urandom_range(99);
    if (kind < 10) begin
      k = $urandom_range(1, 8);
      repeat (k) send_char(8'($urandom_range(255)), 1'b0);
    end else if (kind < 18) begin
      // each level stacks an operator and a '(' so depth can run past the limit
      k = $urandom_range(5, 11);
      repeat (k) begin
        send_num();
        send_char(pick_op(), 1'b0);
        send_char(CH_LPAREN, 1'b0);
      end
      send_num();
      repeat ($urandom_range(0, k + 1)) send_char(CH_RPAREN, 1'b0);
    end else begin
      terms = $urandom_range(1, 6);
      opens = 0;
      for (j = 0; j < terms; j++) begin
        k = $urandom_range(0, 2);
        repeat (k) send_char(CH_LPAREN, 1'b0);
        opens += k;
        if ($urandom_range(4) == 0) send_char(CH_SPACE, 1'b0);
        send_num();
        if ($urandom_range(4) == 0) send_char(CH_SPACE, 1'b0);
        k = $urandom_range(0, opens);
        repeat (k) send_char(CH_RPAREN, 1'b0);
        opens -= k;
        if (j < terms - 1) send_char(pick_op(), 1'b0);
        if (kind >= 85 && $urandom_range(4) == 0) begin
          case ($urandom_range(2))
            0:       send_char(8'($urandom_range(255)), 1'b0);
            1:       send_char(CH_RPAREN, 1'b0);
            default: send_char(CH_LPAREN, 1'b0);
          endcase
        end
      end
      if (kind < 85 || $urandom_range(1) == 0) repeat (opens) send_char(CH_RPAREN, 1'b0);
    end
    send_char(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic run_random(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) gen_expr();
  endtask

  // Stop offering and hold until every expected result has arrived
  task automatic drain_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (postfix_q.size() != 0) @(posedge clk);
  endtask

  task automatic row(input logic [7:0] ch, input bit eoe, input int reps);
    stim_row_t r;
    r.it.in_char     = ch;
    r.it.end_of_expr = eoe;
    r.reps           = reps;
    r.typed          = 1'b0;
    r.want           = '0;
    stim_rows.push_back(r);
  endtask

  task automatic row_exp(input logic [7:0] ch, input bit eoe, input bit has,
                         input logic [7:0] oc, input logic [2:0] st);
    stim_row_t r;
    r.it.in_char     = ch;
    r.it.end_of_expr = eoe;
    r.reps           = 1;
    r.typed          = 1'b1;
    r.want.has_char  = has;
    r.want.out_char  = oc;
    r.want.last      = 1'b1;
    r.want.status    = st;
    stim_rows.push_back(r);
  endtask

  initial begin
    row_exp(CH_NONE,   1'b1, 1'b0, CH_NONE, ST_OK);
    row_exp(8'h7E,     1'b0, 1'b0, CH_NONE, ST_BAD);
    row_exp(CH_RPAREN, 1'b0, 1'b0, CH_NONE, ST_CLOSE);
    row_exp(CH_ZERO,   1'b0, 1'b1, CH_ZERO, ST_OK);
    row_exp(CH_NINE,   1'b0, 1'b1, CH_NINE, ST_OK);
    row_exp(CH_DOT,    1'b0, 1'b1, CH_DOT,  ST_OK);
    row(CH_PLUS,   1'b0, 1);
    row(CH_LPAREN, 1'b0, 1);
    row("1",       1'b0, 1);
    row(CH_STAR,   1'b0, 1);
    row("2",       1'b0, 1);
    row(CH_MINUS,  1'b0, 1);
    row("3",       1'b0, 1);
    row(CH_SLASH,  1'b0, 1);
    row(CH_SPACE,  1'b0, 1);
    row("4",       1'b0, 1);
    row(CH_RPAREN, 1'b0, 1);
    row_exp(8'hFF,     1'b0, 1'b0, CH_NONE, ST_BAD);
    row(CH_LPAREN, 1'b0, 1);
    row(8'hFF,     1'b1, 1);
    // fill the stack with '(' and overflow it
    row(CH_LPAREN, 1'b0, STK_MAX);
    row_exp(CH_STAR,   1'b0, 1'b0, CH_NONE, ST_OVER);
    row_exp(CH_LPAREN, 1'b0, 1'b0, CH_NONE, ST_OVER);
    row(CH_RPAREN, 1'b0, 1);
    row_exp(CH_NONE,   1'b1, 1'b0, CH_NONE, ST_OPEN);
    row("5",       1'b0, 1);
    row(CH_MINUS,  1'b0, 1);
    row(CH_RPAREN, 1'b0, 1);
    row_exp(CH_NONE,   1'b1, 1'b0, CH_NONE, ST_OK);

    send_idle_pct  = 6;
    recv_stall_pct = 73;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i])
      repeat (stim_rows[i].reps) send_item(stim_rows[i].it, stim_rows[i].typed, stim_rows[i].want);
    drain_results();

    run_random(170);
    drain_results();

    send_idle_pct  = 73;
    recv_stall_pct = 6;
    run_random(170);
    drain_results();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    run_random(160);
    item_valid <= 1'b0;

    @(posedge clk);
    while (postfix_q.size() != 0) @(posedge clk);
    repeat (TAIL_LEN) @(posedge clk);

    if (bad_results == 0)
      $display("infix_to_postfix_converter_unit_tb: PASS");
    else
      $display("infix_to_postfix_converter_unit_tb: FAIL");
    $finish;
  end

endmodule
